[rtl/dwr_pkg.sv]
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared types, constants and functions of the DNS wildcard A responder.
// ----------------------------------------------------------------------------
package dwr_pkg;

   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_ANSWER_IPV4   = 2'd0;
   localparam logic [1:0] REG_ANSWER_TTL    = 2'd1;
   localparam logic [1:0] REG_MAX_QUERY_LEN = 2'd2;

   localparam logic [31:0] IPV4_RESET    = 32'hC0A8_0401;
   localparam logic [31:0] TTL_RESET     = 32'd60;
   localparam logic [7:0]  MAX_LEN_RESET = 8'd200;

   localparam logic [7:0] HEADER_LEN   = 8'd12;
   localparam logic [7:0] BUFFER_LIMIT = 8'd240;

   // header byte positions that get rewritten
   localparam logic [7:0] POS_FLAGS_HI = 8'd2;
   localparam logic [7:0] POS_FLAGS_LO = 8'd3;
   localparam logic [7:0] POS_AN_HI    = 8'd6;
   localparam logic [7:0] POS_AN_LO    = 8'd7;
   localparam logic [7:0] POS_NS_HI    = 8'd8;
   localparam logic [7:0] POS_AR_LO    = 8'd11;

   localparam logic [7:0] FLAGS_HI_RESP = 8'h81;   // QR, RD
   localparam logic [7:0] FLAGS_LO_RESP = 8'h80;   // RA, RCODE 0

   localparam logic [3:0] TAIL_LAST_IDX = 4'd15;

   typedef struct packed {
      logic [7:0] query_byte;
      logic       query_last;
   } req_type;

   typedef struct packed {
      logic [7:0] resp_byte;
      logic       resp_last;
      logic       frame_drop;
   } rsp_type;

   typedef struct packed {
      logic [31:0] answer_ipv4;
      logic [31:0] answer_ttl;
      logic [7:0]  max_query_len;
   } cfg_type;

   function automatic logic [7:0] rewrite_header(input logic [7:0] pos,
                                                 input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (pos == POS_FLAGS_HI)
         r = FLAGS_HI_RESP;
      else if (pos == POS_FLAGS_LO)
         r = FLAGS_LO_RESP;
      else if (pos == POS_AN_HI)
         r = 8'h00;
      else if (pos == POS_AN_LO)
         r = 8'h01;
      else if (pos >= POS_NS_HI && pos <= POS_AR_LO)
         r = 8'h00;
      return r;
   endfunction

   // answer record: ptr C00C, type A, class IN, TTL, rdlength 4, address
   function automatic logic [7:0] tail_byte(input logic [3:0]  idx,
                                            input logic [31:0] ttl,
                                            input logic [31:0] ipv4);
      logic [7:0] r;
      case (idx)
         4'd0:    r = 8'hC0;
         4'd1:    r = 8'h0C;
         4'd2:    r = 8'h00;
         4'd3:    r = 8'h01;
         4'd4:    r = 8'h00;
         4'd5:    r = 8'h01;
         4'd6:    r = ttl[31:24];
         4'd7:    r = ttl[23:16];
         4'd8:    r = ttl[15:8];
         4'd9:    r = ttl[7:0];
         4'd10:   r = 8'h00;
         4'd11:   r = 8'h04;
         4'd12:   r = ipv4[31:24];
         4'd13:   r = ipv4[23:16];
         4'd14:   r = ipv4[15:8];
         default: r = ipv4[7:0];
      endcase
      return r;
   endfunction

endpackage

[rtl/dwr_csr.sv]
// ----------------------------------------------------------------------------
// dwr_csr
// APB register file: answer address, answer TTL and query length limit.
// ----------------------------------------------------------------------------
module dwr_csr
   import dwr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg
);

   logic [31:0] ipv4_ff, ipv4_in;
   logic [31:0] ttl_ff, ttl_in;
   logic [7:0]  max_len_ff, max_len_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      ipv4_in    = ipv4_ff;
      ttl_in     = ttl_ff;
      max_len_in = max_len_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ANSWER_IPV4:   ipv4_in    = csr_pwdata;
            REG_ANSWER_TTL:    ttl_in     = csr_pwdata;
            REG_MAX_QUERY_LEN: max_len_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ANSWER_IPV4:   csr_prdata = ipv4_ff;
         REG_ANSWER_TTL:    csr_prdata = ttl_ff;
         REG_MAX_QUERY_LEN: csr_prdata = {24'd0, max_len_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv4_ff    <= IPV4_RESET;
         ttl_ff     <= TTL_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         ipv4_ff    <= ipv4_in;
         ttl_ff     <= ttl_in;
         max_len_ff <= max_len_in;
      end
   end

   assign cfg.answer_ipv4   = ipv4_ff;
   assign cfg.answer_ttl    = ttl_ff;
   assign cfg.max_query_len = max_len_ff;

endmodule

[rtl/dwr_engine.sv]
// ----------------------------------------------------------------------------
// dwr_engine
// Input register, header rewrite, length check, answer tail and result register.
// ----------------------------------------------------------------------------
module dwr_engine
   import dwr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;
   logic [7:0] pos_ff, pos_in;
   logic       exceeded_ff, exceeded_in;
   logic       tail_active_ff, tail_active_in;
   logic [3:0] tail_idx_ff, tail_idx_in;
   logic       drop_ff, drop_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       out_free;
   logic       echo_go;
   logic       tail_go;
   logic       in_take;
   logic [8:0] count;
   logic [7:0] limit;
   logic       exceeded_now;
   logic       tail_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign echo_go   = in_valid_ff && !tail_active_ff && out_free;
   assign tail_go   = tail_active_ff && out_free;
   assign req_stall = in_valid_ff && !echo_go;
   assign in_take   = req_valid && !req_stall;
   assign tail_last = (tail_idx_ff == TAIL_LAST_IDX);

   // byte count including this one, checked against the capped limit
   assign count        = {1'b0, pos_ff} + 9'd1;
   assign limit        = (cfg.max_query_len > BUFFER_LIMIT) ? BUFFER_LIMIT
                                                            : cfg.max_query_len;
   assign exceeded_now = exceeded_ff || (count > {1'b0, limit});

   always_comb begin
      in_valid_in    = in_take || (in_valid_ff && !echo_go);
      pos_in         = pos_ff;
      exceeded_in    = exceeded_ff;
      tail_active_in = tail_active_ff;
      tail_idx_in    = tail_idx_ff;
      drop_in        = drop_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;

      if (echo_go) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.resp_byte  = rewrite_header(pos_ff, in_data_ff.query_byte);
         rsp_data_in.resp_last  = 1'b0;
         rsp_data_in.frame_drop = 1'b0;
         if (in_data_ff.query_last) begin
            pos_in         = '0;
            exceeded_in    = 1'b0;
            tail_active_in = 1'b1;
            tail_idx_in    = '0;
            drop_in        = exceeded_now || (count < {1'b0, HEADER_LEN});
         end else begin
            pos_in      = count[8] ? 8'hFF : count[7:0];
            exceeded_in = exceeded_now;
         end
      end else if (tail_go) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.resp_byte  = tail_byte(tail_idx_ff, cfg.answer_ttl, cfg.answer_ipv4);
         rsp_data_in.resp_last  = tail_last;
         rsp_data_in.frame_drop = tail_last && drop_ff;
         tail_idx_in            = tail_idx_ff + 4'd1;
         if (tail_last)
            tail_active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         pos_ff         <= '0;
         exceeded_ff    <= 1'b0;
         tail_active_ff <= 1'b0;
         tail_idx_ff    <= '0;
         drop_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         pos_ff         <= pos_in;
         exceeded_ff    <= exceeded_in;
         tail_active_ff <= tail_active_in;
         tail_idx_ff    <= tail_idx_in;
         drop_ff        <= drop_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take)
         in_data_ff <= req_data;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/dns_wildcard_a_responder.sv]
// ----------------------------------------------------------------------------
// dns_wildcard_a_responder
// Answers every DNS query with one A record for a configured IPv4 address.
// ----------------------------------------------------------------------------
// Query bytes stream in one per request, pass the input register and the
// result register and leave one per clock while rsp_stall is low, with the
// header flags, ANCOUNT, NSCOUNT and ARCOUNT rewritten. The byte marked last
// is followed by a 16-byte answer record from the answer_ipv4 and answer_ttl
// registers, sent by the single result register one byte per clock while
// rsp_stall is low; req_stall is high while a byte waits behind it. Frames shorter
// than 12 bytes or longer than max_query_len (capped at 240) still get the full
// response, with frame_drop set on the final byte. Registers are meant to be
// written only while no frame is in flight.
module dns_wildcard_a_responder
   import dwr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   cfg_type cfg;

   dwr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dwr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for the DNS wildcard A responder.
// ----------------------------------------------------------------------------
// Query frames stream in byte by byte. A local predictor rebuilds every
// response byte: the header rewrite, the pass-through bytes, the 16-byte
// answer record and the drop flag on the final byte. Each response byte that
// leaves the block is compared against the oldest prediction. Directed frames
// cover these cases:
//    - length boundaries
//    - register extremes
//    - the 240-byte buffer cap
//    - position saturation
//    - limit changes in the middle of a frame
// Random frames then run with random idle cycles on both sides. The run also
// includes a long receiver hold-off and a sender pause.
module testbench;
   import dwr_pkg::*;

   localparam logic [1:0]  REG_UNMAPPED = 2'd3;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned MAX_REPORTS  = 10;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   req_type                 req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   rsp_type                 rsp_data;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   // predictor copy of registers and frame state
   logic [31:0] cfg_ipv4;
   logic [31:0] cfg_ttl;
   logic [7:0]  cfg_max_len;
   logic [7:0]  pred_pos;
   logic        pred_exceeded;
   rsp_type     expected_resp[$];

   bit          sender_idle;
   bit          receiver_idle;
   int unsigned long_hold_cycles;
   int unsigned mismatch_count;
   int unsigned bytes_sent;
   int unsigned frames_sent;
   int unsigned resp_checked;
   int unsigned drops_seen;
   int unsigned stall_cycles;

   dns_wildcard_a_responder u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at response %0d: %s", resp_checked, what);
   endfunction

   // expected response bytes for one accepted request
   function automatic void predict_response(input req_type q);
      logic [8:0]   count;
      logic [7:0]   limit;
      logic [127:0] answer;
      logic         drop;
      rsp_type      r;
      int           k;
      count = {1'b0, pred_pos} + 9'd1;
      limit = (cfg_max_len > BUFFER_LIMIT) ? BUFFER_LIMIT : cfg_max_len;
      if (count > {1'b0, limit})
         pred_exceeded = 1'b1;
      case (pred_pos)
         8'd2:                      r.resp_byte = 8'h81;
         8'd3:                      r.resp_byte = 8'h80;
         8'd7:                      r.resp_byte = 8'h01;
         8'd6, 8'd8, 8'd9, 8'd10,
         8'd11:                     r.resp_byte = 8'h00;
         default:                   r.resp_byte = q.query_byte;
      endcase
      r.resp_last  = 1'b0;
      r.frame_drop = 1'b0;
      expected_resp.push_back(r);
      if (!q.query_last) begin
         pred_pos = (count > 9'd255) ? 8'd255 : count[7:0];
         return;
      end
      drop   = pred_exceeded || (count < {1'b0, HEADER_LEN});
      answer = {8'hC0, 8'h0C, 16'h0001, 16'h0001, cfg_ttl, 16'h0004, cfg_ipv4};
      for (k = 0; k < 16; k++) begin
         r.resp_byte  = answer[127 - 8*k -: 8];
         r.resp_last  = (k == 15);
         r.frame_drop = (k == 15) && drop;
         expected_resp.push_back(r);
      end
      pred_pos      = 8'd0;
      pred_exceeded = 1'b0;
   endfunction

   always @(posedge clock) begin : response_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         resp_checked++;
         if (expected_resp.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b drop %0b",
                                      rsp_data.resp_byte, rsp_data.resp_last,
                                      rsp_data.frame_drop));
         end else begin
            want = expected_resp.pop_front();
            if (rsp_data.resp_byte !== want.resp_byte)
               report_mismatch($sformatf("resp_byte expected %02h, got %02h",
                                         want.resp_byte, rsp_data.resp_byte));
            if (rsp_data.resp_last !== want.resp_last)
               report_mismatch($sformatf("resp_last expected %0b, got %0b",
                                         want.resp_last, rsp_data.resp_last));
            if (rsp_data.frame_drop !== want.frame_drop)
               report_mismatch($sformatf("frame_drop expected %0b, got %0b",
                                         want.frame_drop, rsp_data.frame_drop));
            if (want.resp_last && want.frame_drop)
               drops_seen++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         stall_cycles = 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("dns_wildcard_a_responder regression: fail");
         $finish;
      end else begin
         stall_cycles++;
      end
   end

   // response side: random stall before each byte, or one long hold-off
   initial begin : receiver
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         hold = 0;
         if (long_hold_cycles != 0) begin
            hold = long_hold_cycles;
            long_hold_cycles = 0;
         end else if (receiver_idle && rsp_valid && !rsp_stall) begin
            hold = $urandom_range(0, 11);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_query_byte(input logic [7:0] value, input logic last);
      int unsigned gap;
      gap = sender_idle ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{query_byte: value, query_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_response(req_data);
      bytes_sent++;
      if (last)
         frames_sent++;
   endtask

   task automatic send_frame(input int unsigned len);
      int unsigned i;
      for (i = 0; i < len; i++)
         send_query_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   // stop offering requests and wait until every predicted byte has come out
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_resp.size() != 0);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         REG_ANSWER_IPV4:   cfg_ipv4    = value;
         REG_ANSWER_TTL:    cfg_ttl     = value;
         REG_MAX_QUERY_LEN: cfg_max_len = value[7:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_csr(input logic [1:0] index);
      logic [31:0] want;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         REG_ANSWER_IPV4:   want = cfg_ipv4;
         REG_ANSWER_TTL:    want = cfg_ttl;
         default:           want = {24'd0, cfg_max_len};
      endcase
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %0d read expected %08h, got %08h",
                                   index, want, csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] ipv4, input logic [31:0] ttl,
                             input logic [31:0] max_len);
      write_csr(REG_ANSWER_IPV4, ipv4);
      write_csr(REG_ANSWER_TTL, ttl);
      write_csr(REG_MAX_QUERY_LEN, max_len);
   endtask

   // reset config: one-byte frame, one short of a header, exactly a header
   task automatic test_header_boundaries();
      int unsigned i;
      send_query_byte(8'hFF, 1'b1);
      for (i = 0; i < 11; i++)
         send_query_byte(i[0] ? 8'hFF : 8'h00, i == 10);
      for (i = 0; i < 12; i++)
         send_query_byte(i[0] ? 8'h00 : 8'hFF, i == 11);
   endtask

   task automatic test_register_access();
      int unsigned i;
      drain_responses();
      // upper bits of the length write must be ignored
      set_config(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FF0C);
      write_csr(REG_UNMAPPED, 32'h5A5A_A5A5);
      for (i = 0; i < 3; i++)
         check_csr(2'(i));
      send_frame(12);
      send_frame(13);
      drain_responses();
      set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'd200);
      for (i = 0; i < 3; i++)
         check_csr(2'(i));
      send_frame(12);
   endtask

   // a limit under the header length drops every frame
   task automatic test_limit_below_header();
      drain_responses();
      write_csr(REG_MAX_QUERY_LEN, 32'd0);
      send_frame(12);
      send_frame(1);
      drain_responses();
      write_csr(REG_MAX_QUERY_LEN, 32'd11);
      send_frame(12);
      send_frame(11);
   endtask

   // limit above 240 is capped; frames past 255 bytes saturate the position
   task automatic test_buffer_cap();
      drain_responses();
      set_config($urandom, $urandom, 32'd255);
      send_frame(241);
      send_frame(260);
   endtask

   task automatic test_limit_change_mid_frame();
      int unsigned i;
      drain_responses();
      write_csr(REG_MAX_QUERY_LEN, 32'd200);
      for (i = 0; i < 15; i++)
         send_query_byte(8'($urandom_range(0, 255)), 1'b0);
      drain_responses();
      write_csr(REG_MAX_QUERY_LEN, 32'd12);
      // over the lowered limit: the frame stays marked after the limit rises
      send_query_byte(8'($urandom_range(0, 255)), 1'b0);
      drain_responses();
      write_csr(REG_MAX_QUERY_LEN, 32'd200);
      for (i = 0; i < 4; i++)
         send_query_byte(8'($urandom_range(0, 255)), i == 3);
      drain_responses();
      write_csr(REG_MAX_QUERY_LEN, 32'd12);
      for (i = 0; i < 10; i++)
         send_query_byte(8'($urandom_range(0, 255)), 1'b0);
      drain_responses();
      write_csr(REG_MAX_QUERY_LEN, 32'd200);
      for (i = 0; i < 10; i++)
         send_query_byte(8'($urandom_range(0, 255)), i == 9);
   endtask

   task automatic test_backpressure();
      drain_responses();
      set_config($urandom, $urandom, 32'd200);
      sender_idle      = 1'b0;
      receiver_idle    = 1'b0;
      long_hold_cycles = 150;
      send_frame(12);
      send_frame(12);
      send_frame(12);
      // sender waits for the whole backlog before the next request
      drain_responses();
      send_frame(12);
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   task automatic test_random_frames();
      int unsigned phase;
      int unsigned stop_at;
      int unsigned limit;
      int unsigned kind;
      int unsigned len;
      for (phase = 0; phase < 4; phase++) begin
         drain_responses();
         set_config($urandom, $urandom,
                    {24'($urandom_range(0, 32'hFF_FFFF)), 8'($urandom_range(12, 48))});
         limit   = 32'(cfg_max_len);
         stop_at = bytes_sent + 25;
         while (bytes_sent < stop_at) begin
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind == 0)
               len = $urandom_range(1, 11);
            else if (kind == 1)
               len = $urandom_range(limit + 1, limit + 6);
            else
               len = $urandom_range(12, limit);
            send_frame(len);
         end
      end
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      sender_idle      = 1'b1;
      receiver_idle    = 1'b1;
      long_hold_cycles = 0;
      mismatch_count   = 0;
      bytes_sent       = 0;
      frames_sent      = 0;
      resp_checked     = 0;
      drops_seen       = 0;
      stall_cycles     = 0;
      cfg_ipv4         = IPV4_RESET;
      cfg_ttl          = TTL_RESET;
      cfg_max_len      = MAX_LEN_RESET;
      pred_pos         = 8'd0;
      pred_exceeded    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_header_boundaries();
      test_register_access();
      test_limit_below_header();
      test_buffer_cap();
      test_limit_change_mid_frame();
      test_backpressure();
      test_random_frames();

      drain_responses();
      repeat (8) @(posedge clock);
      $display("covered %0d frames, %0d query bytes, %0d response bytes checked",
               frames_sent, bytes_sent, resp_checked);
      $display("%0d frames flagged for drop; %0d mismatches", drops_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("dns_wildcard_a_responder regression: pass");
      else
         $display("dns_wildcard_a_responder regression: fail");
      $finish;
   end

endmodule

[filelist.f]
rtl/dwr_pkg.sv
rtl/dwr_csr.sv
rtl/dwr_engine.sv
rtl/dns_wildcard_a_responder.sv
bench/testbench.sv
